// File: design/mvei_pkg.sv
package mvei_pkg;

  localparam int unsigned VAL_W   = 52;
  localparam int unsigned HALF_W  = VAL_W / 2;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned OP_W    = 2;
  localparam logic [DIG_W-1:0] DIGIT_MAX = 4'd9;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_RSV = 2'd3
  } op_e;

endpackage

// File: design/mvei_ifs.sv
interface mvei_in_if;
  import mvei_pkg::*;
  logic             valid;
  logic             ready;
  logic [DIG_W-1:0] digit_value;
  logic [OP_W-1:0]  next_op;
  logic             last_digit;

  modport source (output valid, digit_value, next_op, last_digit, input ready);
  modport sink   (input valid, digit_value, next_op, last_digit, output ready);
endinterface

interface mvei_out_if;
  import mvei_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] max_value;
  logic                    too_long;

  modport source (output valid, max_value, too_long, input ready);
  modport sink   (input valid, max_value, too_long, output ready);
endinterface

// File: design/mvei_ram.sv
module mvei_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                   wdata_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] ra_addr_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rb_addr_i,
  output logic [WIDTH-1:0]                   ra_data_o,
  output logic [WIDTH-1:0]                   rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule

// File: design/mvei_queue.sv
module mvei_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             avail_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign avail_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: design/mvei_front.sv
module mvei_front #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mvei_in_if.sink in_i,
  input  logic q_full_i,
  output logic push_o,
  output logic [MAX_DIGITS*(mvei_pkg::DIG_W+mvei_pkg::OP_W)+$clog2(MAX_DIGITS+2):0] job_o
);
  import mvei_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIGITS + 2);
  localparam int unsigned IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [MAX_DIGITS-1:0][DIG_W-1:0] dig_q, dig_d;
  logic [MAX_DIGITS-1:0][OP_W-1:0]  op_q, op_d;
  logic [CW-1:0]                    cnt_q, cnt_d;
  logic                             accept;
  logic [DIG_W-1:0]                 dsat;

  assign in_i.ready = ~q_full_i;
  assign accept     = in_i.valid & ~q_full_i;
  assign dsat       = (in_i.digit_value > DIGIT_MAX) ? DIGIT_MAX : in_i.digit_value;

  always_comb begin
    dig_d = dig_q;
    op_d  = op_q;
    cnt_d = cnt_q;
    if (cnt_q < CW'(MAX_DIGITS)) begin
      dig_d[cnt_q[IW-1:0]] = dsat;
      op_d[cnt_q[IW-1:0]]  = in_i.next_op;
    end
    if (cnt_q <= CW'(MAX_DIGITS)) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  // Hand the whole expression over on the last digit.
  assign push_o = accept & in_i.last_digit;
  assign job_o  = {(cnt_d > CW'(MAX_DIGITS)), cnt_d, op_d, dig_d};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dig_q <= dig_d;
      op_q  <= op_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= in_i.last_digit ? '0 : cnt_d;
    end
  end

endmodule

// File: design/mvei_back.sv
module mvei_back #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_avail_i,
  input  logic [MAX_DIGITS*(mvei_pkg::DIG_W+mvei_pkg::OP_W)+$clog2(MAX_DIGITS+2):0] job_i,
  output logic pop_o,
  mvei_out_if.source out_o
);
  import mvei_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_DIGITS + 2);
  localparam int unsigned IW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned DEPTH = MAX_DIGITS * MAX_DIGITS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW    = MAX_DIGITS * DIG_W;
  localparam int unsigned OW    = MAX_DIGITS * OP_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_READ, ST_COMBO, ST_DRAIN, ST_WRITE, ST_FREAD, ST_FOUT, ST_OUT
  } state_e;

  state_e                           state_q;
  logic [MAX_DIGITS-1:0][DIG_W-1:0] dig_q;
  logic [MAX_DIGITS-1:0][OP_W-1:0]  ops_q;
  logic [IW-1:0]                    last_q, len_q, i_q, k_q;
  logic [1:0]                       q_q;
  logic                             first_q;
  logic signed [VAL_W-1:0]          hi_q, lo_q, res_q;
  logic                             tl_q;
  logic                             ovalid_q;
  logic signed [VAL_W-1:0]          omax_q;
  logic                             otl_q;
  logic [IW-1:0]                    j;
  logic [AW-1:0]                    ra, rb, wa;
  logic                             we;
  logic [VAL_W-1:0]                 wmax, wmin;
  logic [VAL_W-1:0]                 amax, amin, bmax, bmin;
  logic [CW-1:0]                    job_n;

  assign j  = i_q + len_q;
  assign ra = AW'(i_q) * AW'(MAX_DIGITS) + AW'(k_q);
  assign rb = AW'(k_q + IW'(1)) * AW'(MAX_DIGITS) + AW'(j);
  assign we = (state_q == ST_INIT) || (state_q == ST_WRITE);
  assign wa = AW'(i_q) * AW'(MAX_DIGITS) + AW'(j);
  assign wmax = (state_q == ST_INIT) ? VAL_W'(dig_q[i_q]) : hi_q;
  assign wmin = (state_q == ST_INIT) ? VAL_W'(dig_q[i_q]) : lo_q;
  assign job_n = job_i[DW+OW +: CW];

  mvei_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_max_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wmax),
    .ra_addr_i(ra), .rb_addr_i(rb), .ra_data_o(amax), .rb_data_o(bmax)
  );
  mvei_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_min_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wmin),
    .ra_addr_i(ra), .rb_addr_i(rb), .ra_data_o(amin), .rb_data_o(bmin)
  );

  // Combine pipeline: partial products, then final sum.
  logic [VAL_W-1:0]  opa, opb;
  op_e               opc;
  logic              v1_q, v2_q, mul1_q;
  logic [VAL_W-1:0]  pll_q, as_q;
  logic [HALF_W-1:0] x1_q, x2_q;
  logic signed [VAL_W-1:0] r2_q;

  assign opc = op_e'(ops_q[k_q]);

  always_comb begin
    unique case (q_q)
      2'd0:    begin opa = amin; opb = bmax; end
      2'd1:    begin opa = amax; opb = bmin; end
      2'd2:    begin opa = amin; opb = bmin; end
      default: begin opa = amax; opb = bmax; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pll_q  <= opa[HALF_W-1:0] * opb[HALF_W-1:0];
    x1_q   <= opa[VAL_W-1:HALF_W] * opb[HALF_W-1:0];
    x2_q   <= opa[HALF_W-1:0] * opb[VAL_W-1:HALF_W];
    as_q   <= (opc == OP_SUB) ? opa - opb : opa + opb;
    mul1_q <= (opc == OP_MUL);
    r2_q   <= mul1_q ? pll_q + {x1_q + x2_q, {HALF_W{1'b0}}} : as_q;
  end

  assign pop_o          = (state_q == ST_IDLE) && job_avail_i;
  assign out_o.valid     = ovalid_q;
  assign out_o.max_value = omax_q;
  assign out_o.too_long  = otl_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dig_q <= job_i[0 +: DW];
      ops_q <= job_i[DW +: OW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      last_q   <= '0;
      len_q    <= '0;
      i_q      <= '0;
      k_q      <= '0;
      q_q      <= '0;
      first_q  <= 1'b1;
      hi_q     <= '0;
      lo_q     <= '0;
      res_q    <= '0;
      tl_q     <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      ovalid_q <= 1'b0;
      omax_q   <= '0;
      otl_q    <= 1'b0;
    end else begin
      v1_q <= (state_q == ST_COMBO);
      v2_q <= v1_q;
      if (out_o.ready && (state_q != ST_OUT)) ovalid_q <= 1'b0;
      // Fold each finished combination into the running extremes.
      if (v2_q) begin
        if (first_q || r2_q > hi_q) hi_q <= r2_q;
        if (first_q || r2_q < lo_q) lo_q <= r2_q;
        first_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_avail_i) begin
            tl_q   <= job_i[DW+OW+CW];
            last_q <= IW'(job_n - CW'(1));
            len_q  <= '0;
            i_q    <= '0;
            k_q    <= '0;
            if (job_i[DW+OW+CW]) begin
              res_q   <= '0;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          if (i_q == last_q) begin
            i_q <= '0;
            if (last_q == '0) begin
              k_q     <= '0;
              state_q <= ST_FREAD;
            end else begin
              len_q   <= IW'(1);
              k_q     <= '0;
              first_q <= 1'b1;
              state_q <= ST_READ;
            end
          end else begin
            i_q <= i_q + IW'(1);
          end
        end
        ST_READ: begin
          q_q     <= '0;
          state_q <= ST_COMBO;
        end
        ST_COMBO: begin
          q_q <= q_q + 2'd1;
          if (q_q == 2'd3) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!v1_q && !v2_q) begin
            if (k_q + IW'(1) == j) begin
              state_q <= ST_WRITE;
            end else begin
              k_q     <= k_q + IW'(1);
              state_q <= ST_READ;
            end
          end
        end
        ST_WRITE: begin
          first_q <= 1'b1;
          if (j == last_q) begin
            if (len_q == last_q) begin
              i_q     <= '0;
              k_q     <= last_q;
              state_q <= ST_FREAD;
            end else begin
              len_q   <= len_q + IW'(1);
              i_q     <= '0;
              k_q     <= '0;
              state_q <= ST_READ;
            end
          end else begin
            i_q     <= i_q + IW'(1);
            k_q     <= i_q + IW'(1);
            state_q <= ST_READ;
          end
        end
        ST_FREAD: begin
          state_q <= ST_FOUT;
        end
        ST_FOUT: begin
          res_q   <= amax;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!ovalid_q || out_o.ready) begin
            ovalid_q <= 1'b1;
            omax_q   <= res_q;
            otl_q    <= tl_q;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: design/max_value_expression_interval_dp.sv
// An overlong expression skips the interval sweep and goes straight to the output register.
// Throughput: one digit per cycle on input unless the job queue is full; one expression
// at a time in the evaluator; split points share the combine pipeline and table ports.
// Reset (rst_ni, async, active low) clears the digit count, queue, sequencer and output
// valid; the interval tables are not cleared.
module max_value_expression_interval_dp #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mvei_in_if.sink    in_i,
  mvei_out_if.source out_o
);
  import mvei_pkg::*;

  localparam int unsigned JW = MAX_DIGITS * (DIG_W + OP_W) + $clog2(MAX_DIGITS + 2) + 1;

  logic          q_full, q_avail, push, pop;
  logic [JW-1:0] push_job, pop_job;

  // Front end: collect digits and operators, hand off a full expression.
  mvei_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk_i, .rst_ni, .in_i,
    .q_full_i(q_full), .push_o(push), .job_o(push_job)
  );

  // Two-deep job queue: loading of the next expression proceeds during evaluation.
  mvei_queue #(.WIDTH(JW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_job), .full_o(q_full),
    .avail_o(q_avail), .pop_i(pop), .pop_data_o(pop_job)
  );

  // Back end: interval sweep over the min/max tables, then register the answer.
  mvei_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk_i, .rst_ni,
    .job_avail_i(q_avail), .job_i(pop_job), .pop_o(pop), .out_o
  );

endmodule

// File: design/mvei_chk.sv
module mvei_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [51:0] out_max_i,
  input logic        out_tl_i
);

  a_tl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_tl_i |-> out_max_i == '0)
    else $error("overlong result not zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_max_i))
    else $error("result dropped while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> in_valid_i && $stable(in_last_i))
    else $error("input transfer withdrawn while stalled");

endmodule

bind max_value_expression_interval_dp mvei_chk u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_i.valid), .in_ready_i(in_i.ready), .in_last_i(in_i.last_digit),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .out_max_i(out_o.max_value), .out_tl_i(out_o.too_long)
);
